>>> hw/rtl/pdt_pkg.sv
// Shared types and constants of the pulse discriminator trigger.
package pdt_pkg;

	localparam int NUM_CHANNELS = 32;
	localparam int MAX_TICKS    = 2048;
	localparam int PRE_DELAY    = 4;
	localparam int MAIN_DELAY   = 4;
	localparam int PEAK_WIDTH   = 6;
	localparam int MIN_READOUT  = 1500;
	localparam int MAX_OUT      = 64;
	localparam int RING         = 8;
	localparam int QUEUE_DEPTH  = 4;

	localparam int RING_W   = $clog2(RING);
	localparam int TICK_W   = $clog2(MAX_TICKS);
	localparam int TCNT_W   = TICK_W + 1;
	localparam int SAMPLE_W = 12;
	localparam int DIFF_W   = SAMPLE_W + 1;
	localparam int SUM_W    = 17;
	localparam int HIT_W    = 6;
	localparam int CH_W     = $clog2(NUM_CHANNELS + 1);
	localparam int WIN_W    = 18;
	localparam int IDX_W    = $clog2(MAX_OUT) + 1;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 12;
	localparam int QPTR_W   = $clog2(QUEUE_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_PRE_THRESHOLD  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRE_HOLDOFF    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRE_WINDOW     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAIN_THRESHOLD = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAIN_DEADTIME  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SINGLE_WINDOW  = 4'd7;

	typedef struct packed {
		logic [11:0] pre_threshold;
		logic [10:0] pre_holdoff;
		logic [10:0] pre_window;
		logic [11:0] main_threshold;
		logic [10:0] main_deadtime;
		logic [10:0] window_size;
		logic [10:0] window_start;
		logic        single_window;
	} cfg_t;

	typedef struct packed {
		logic [11:0] sample;
		logic        channel_end;
		logic        event_end;
	} in_t;

	typedef struct packed {
		logic [5:0]  window_index;
		logic [16:0] peak_sum;
		logic [5:0]  peak_hits;
		logic        no_window;
		logic        last;
	} out_t;

	// one classified tick passed from front to back
	typedef struct packed {
		logic [TICK_W-1:0]        tick;
		logic signed [DIFF_W-1:0] dp;
		logic signed [DIFF_W-1:0] dm;
		logic                     has_sample;
		logic                     chan_end;
		logic                     ev_end;
	} rec_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [HIT_W-1:0] hits;
	} acc_t;

endpackage

>>> hw/rtl/pulse_discriminator_trigger_core.sv
// Top level of the pulse discriminator trigger: config registers and block wiring.
//
//  channel   handshake                 payload
//  input     push / full               item      (sample, channel_end, event_end)
//  result    empty / pop               result    (window_index .. last)
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// The back end steps through take, decide, finish for a sample, and a write when the
// decided tick adds into the accumulator RAM; a channel end decides up to six ticks.
// The front takes a sample whenever the four-deep queue has room; full holds otherwise.
// At an event end the readout checks, scans, drains and emits each window, one RAM
// word a cycle; results wait in one output register, and a held result stalls it.
// After reset and after every event the accumulator RAM is cleared, one word a cycle,
// through all 2048 words, while samples wait in the queue.
module pulse_discriminator_trigger_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  pdt_pkg::in_t                     item,
	output logic                             empty,
	input  logic                             pop,
	output pdt_pkg::out_t                    result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pdt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pdt_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pdt_pkg::*;

	cfg_t cfg_q;
	rec_t f_rec;
	rec_t q_rec;
	logic f_push;
	logic q_full;
	logic q_empty;
	logic q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{window_size: 11'd1, default: '0};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PRE_THRESHOLD:  cfg_q.pre_threshold  <= cfg_data;
				REG_PRE_HOLDOFF:    cfg_q.pre_holdoff    <= cfg_data[10:0];
				REG_PRE_WINDOW:     cfg_q.pre_window     <= cfg_data[10:0];
				REG_MAIN_THRESHOLD: cfg_q.main_threshold <= cfg_data;
				REG_MAIN_DEADTIME:  cfg_q.main_deadtime  <= cfg_data[10:0];
				REG_WINDOW_SIZE:    cfg_q.window_size    <= cfg_data[10:0];
				REG_WINDOW_START:   cfg_q.window_start   <= cfg_data[10:0];
				REG_SINGLE_WINDOW:  cfg_q.single_window  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	pdt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.rec_push (f_push),
		.rec      (f_rec),
		.rec_full (q_full)
	);

	pdt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.full   (q_full),
		.wdata  (f_rec),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rec)
	);

	pdt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.rec_empty (q_empty),
		.rec_pop   (q_pop),
		.rec       (q_rec),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

>>> hw/rtl/pdt_front.sv
// Front end: tick counting and delayed differences of incoming samples.
module pdt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  pdt_pkg::in_t  item,
	output logic          rec_push,
	output pdt_pkg::rec_t rec,
	input  logic          rec_full
);
	import pdt_pkg::*;

	logic [SAMPLE_W-1:0] ring_q [RING];
	logic [TCNT_W-1:0]   tick_q;
	logic                take;
	logic                has;
	logic                endf;
	logic [TICK_W-1:0]   n;

	assign full = rec_full;
	assign take = push && !rec_full;
	assign has  = tick_q < TCNT_W'(MAX_TICKS);
	assign endf = item.channel_end || item.event_end;
	assign n    = tick_q[TICK_W-1:0];

	always_comb begin
		rec.tick       = has ? n : TICK_W'(MAX_TICKS - 1);
		rec.has_sample = has;
		rec.chan_end   = endf;
		rec.ev_end     = item.event_end;
		rec.dp         = '0;
		rec.dm         = '0;
		if (tick_q >= TCNT_W'(PRE_DELAY)) begin
			rec.dp = $signed({1'b0, item.sample})
				- $signed({1'b0, ring_q[RING_W'(n - TICK_W'(PRE_DELAY))]});
		end
		if (tick_q >= TCNT_W'(MAIN_DELAY)) begin
			rec.dm = $signed({1'b0, item.sample})
				- $signed({1'b0, ring_q[RING_W'(n - TICK_W'(MAIN_DELAY))]});
		end
	end

	assign rec_push = take && (has || endf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (take) begin
			if (endf) begin
				tick_q <= '0;
			end else if (has) begin
				tick_q <= tick_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && has) begin
			ring_q[n[RING_W-1:0]] <= item.sample;
		end
	end

endmodule

>>> hw/rtl/pdt_fifo.sv
// Short queue of classified ticks between front and back.
module pdt_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  pdt_pkg::rec_t wdata,
	input  logic          pop,
	output logic          empty,
	output pdt_pkg::rec_t rdata
);
	import pdt_pkg::*;

	rec_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

>>> hw/rtl/pdt_back.sv
// Back end: decision sequencer, tick accumulators and window readout.
module pdt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  pdt_pkg::cfg_t cfg,
	input  logic          rec_empty,
	output logic          rec_pop,
	input  pdt_pkg::rec_t rec,
	output pdt_pkg::out_t result,
	output logic          empty,
	input  logic          pop
);
	import pdt_pkg::*;

	typedef enum logic [10:0] {
		S_CLEAR  = 11'b00000000001,
		S_IDLE   = 11'b00000000010,
		S_DEC    = 11'b00000000100,
		S_WR     = 11'b00000001000,
		S_FIN    = 11'b00000010000,
		S_RSTART = 11'b00000100000,
		S_RCHECK = 11'b00001000000,
		S_SCAN   = 11'b00010000000,
		S_DRAIN  = 11'b00100000000,
		S_EMIT   = 11'b01000000000,
		S_NOWIN  = 11'b10000000000
	} state_t;

	state_t                   state_q;
	acc_t                     mem_q [MAX_TICKS];
	acc_t                     rd_q;
	logic                     mem_we;
	logic [TICK_W-1:0]        mem_waddr;
	logic [TICK_W-1:0]        mem_raddr;
	acc_t                     mem_wdata;

	logic signed [DIFF_W-1:0] dp_ring_q [RING];
	logic signed [DIFF_W-1:0] dm_ring_q [RING];
	logic [TICK_W-1:0]        clr_q;
	logic [TICK_W-1:0]        d_q;
	logic [TICK_W-1:0]        d_stop_q;
	logic [TICK_W-1:0]        n_q;
	logic                     end_q;
	logic                     ev_q;
	logic                     pre_seen_q;
	logic                     main_seen_q;
	logic [TICK_W-1:0]        last_pre_q;
	logic [TICK_W-1:0]        last_main_q;
	logic [TICK_W-1:0]        hold_q;
	logic [SAMPLE_W-1:0]      held_q;
	logic [CH_W-1:0]          chan_q;
	logic [TCNT_W-1:0]        len_q;
	logic [TICK_W-1:0]        acc_addr_q;
	logic [SAMPLE_W-1:0]      acc_val_q;
	logic [IDX_W-1:0]         i_q;
	logic [WIN_W-1:0]         ws_q;
	logic [WIN_W-1:0]         we_q;
	logic [TICK_W-1:0]        t_q;
	logic                     rv_s1;
	logic [SUM_W-1:0]         best_sum_q;
	logic [HIT_W-1:0]         best_hits_q;
	logic                     out_valid_q;
	out_t                     out_q;

	// decision of tick d_q
	logic signed [DIFF_W-1:0] dp_c;
	logic signed [DIFF_W-1:0] dm_c;
	logic signed [DIFF_W-1:0] peak_c;
	logic                     main_free;
	logic                     pre_fire;
	logic                     pre_seen_n;
	logic [TICK_W-1:0]        last_pre_n;
	logic                     main_fire;
	logic [TICK_W-1:0]        hold_n;
	logic [SAMPLE_W-1:0]      val_c;
	logic                     acc_do;
	logic                     acc_en;

	// intake of a new record
	logic [TCNT_W-1:0]        n12;
	logic [TCNT_W-1:0]        flush_lo;
	logic                     norm;
	logic                     flush_ok;

	logic [WIN_W-1:0]         we_c;
	logic                     last_c;
	logic                     out_free;
	logic                     out_load;

	assign result   = out_q;
	assign empty    = !out_valid_q;
	assign out_free = !out_valid_q || pop;
	assign out_load = ((state_q == S_EMIT) || (state_q == S_NOWIN)) && out_free;
	assign rec_pop  = (state_q == S_IDLE) && !rec_empty;

	always_comb begin
		dp_c       = dp_ring_q[d_q[RING_W-1:0]];
		dm_c       = dm_ring_q[d_q[RING_W-1:0]];
		main_free  = !main_seen_q ||
			(({1'b0, last_main_q} + {1'b0, cfg.main_deadtime}) < {1'b0, d_q});
		pre_fire   = (dp_c >= $signed({1'b0, cfg.pre_threshold})) && main_free &&
			(!pre_seen_q ||
			(({1'b0, last_pre_q} + {1'b0, cfg.pre_holdoff}) < {1'b0, d_q}));
		pre_seen_n = pre_seen_q || pre_fire;
		last_pre_n = pre_fire ? d_q : last_pre_q;
		main_fire  = (dm_c >= $signed({1'b0, cfg.main_threshold})) && pre_seen_n &&
			((d_q - last_pre_n) < cfg.pre_window) && main_free;
		peak_c     = dm_c;
		for (int j = 1; j < PEAK_WIDTH; j++) begin
			if (({1'b0, d_q} + TCNT_W'(j)) <= {1'b0, n_q}) begin
				if (dm_ring_q[RING_W'(d_q + TICK_W'(j))] > peak_c) begin
					peak_c = dm_ring_q[RING_W'(d_q + TICK_W'(j))];
				end
			end
		end
		hold_n = main_fire ? cfg.main_deadtime : hold_q;
		val_c  = main_fire ? peak_c[SAMPLE_W-1:0] : held_q;
		acc_do = hold_n != '0;
		acc_en = acc_do && (chan_q < CH_W'(NUM_CHANNELS));
	end

	always_comb begin
		n12      = {1'b0, rec.tick};
		norm     = rec.has_sample && (n12 >= TCNT_W'(PEAK_WIDTH - 1));
		flush_lo = (n12 + TCNT_W'(2) >= TCNT_W'(PEAK_WIDTH)) ?
			(n12 + TCNT_W'(2) - TCNT_W'(PEAK_WIDTH)) : '0;
		flush_ok = rec.chan_end && (flush_lo <= n12);
	end

	assign we_c   = ws_q + WIN_W'(cfg.window_size);
	assign last_c = cfg.single_window ||
		((we_q + WIN_W'(cfg.window_size)) >= WIN_W'(len_q)) ||
		(i_q == IDX_W'(MAX_OUT - 1));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_raddr = d_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_WR: begin
				mem_we         = 1'b1;
				mem_waddr      = acc_addr_q;
				mem_wdata.sum  = rd_q.sum + SUM_W'(acc_val_q);
				mem_wdata.hits = rd_q.hits + 1'b1;
			end
			S_SCAN: begin
				mem_raddr = t_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem_q[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (rec_pop && rec.has_sample) begin
			dp_ring_q[rec.tick[RING_W-1:0]] <= rec.dp;
			dm_ring_q[rec.tick[RING_W-1:0]] <= rec.dm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			d_q         <= '0;
			d_stop_q    <= '0;
			n_q         <= '0;
			end_q       <= 1'b0;
			ev_q        <= 1'b0;
			pre_seen_q  <= 1'b0;
			main_seen_q <= 1'b0;
			last_pre_q  <= '0;
			last_main_q <= '0;
			hold_q      <= '0;
			held_q      <= '0;
			chan_q      <= '0;
			len_q       <= '0;
			i_q         <= '0;
			ws_q        <= '0;
			we_q        <= '0;
			t_q         <= '0;
			rv_s1       <= 1'b0;
			best_sum_q  <= '0;
			best_hits_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rv_s1 <= state_q == S_SCAN;
			if (rv_s1) begin
				if (rd_q.sum > best_sum_q) begin
					best_sum_q <= rd_q.sum;
				end
				if (rd_q.hits > best_hits_q) begin
					best_hits_q <= rd_q.hits;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == TICK_W'(MAX_TICKS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!rec_empty) begin
						n_q   <= rec.tick;
						end_q <= rec.chan_end;
						ev_q  <= rec.ev_end;
						priority if (norm) begin
							d_q      <= rec.tick - TICK_W'(PEAK_WIDTH - 1);
							d_stop_q <= rec.chan_end ? rec.tick
								: rec.tick - TICK_W'(PEAK_WIDTH - 1);
							state_q  <= S_DEC;
						end else if (flush_ok) begin
							d_q      <= flush_lo[TICK_W-1:0];
							d_stop_q <= rec.tick;
							state_q  <= S_DEC;
						end else if (rec.chan_end) begin
							state_q <= S_FIN;
						end
					end
				end
				S_DEC: begin
					pre_seen_q <= pre_seen_n;
					last_pre_q <= last_pre_n;
					if (main_fire) begin
						main_seen_q <= 1'b1;
						last_main_q <= d_q;
						held_q      <= peak_c[SAMPLE_W-1:0];
					end
					hold_q <= acc_do ? hold_n - 1'b1 : '0;
					priority if (acc_en) begin
						acc_addr_q <= d_q;
						acc_val_q  <= val_c;
						state_q    <= S_WR;
					end else if (d_q == d_stop_q) begin
						state_q <= S_FIN;
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
				S_WR: begin
					if (d_q == d_stop_q) begin
						state_q <= S_FIN;
					end else begin
						d_q     <= d_q + 1'b1;
						state_q <= S_DEC;
					end
				end
				S_FIN: begin
					if (end_q) begin
						if (chan_q == '0) begin
							len_q <= {1'b0, n_q} + 1'b1;
						end
						if (chan_q < CH_W'(NUM_CHANNELS)) begin
							chan_q <= chan_q + 1'b1;
						end
						pre_seen_q  <= 1'b0;
						main_seen_q <= 1'b0;
						last_pre_q  <= '0;
						last_main_q <= '0;
						hold_q      <= '0;
						held_q      <= '0;
						state_q     <= ev_q ? S_RSTART : S_IDLE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RSTART: begin
					i_q  <= '0;
					ws_q <= WIN_W'(cfg.window_start);
					if ((cfg.window_size == '0) ||
						(!cfg.single_window && (len_q < TCNT_W'(MIN_READOUT)))) begin
						state_q <= S_NOWIN;
					end else begin
						state_q <= S_RCHECK;
					end
				end
				S_RCHECK: begin
					if (we_c < WIN_W'(len_q)) begin
						t_q         <= ws_q[TICK_W-1:0];
						we_q        <= we_c;
						best_sum_q  <= '0;
						best_hits_q <= '0;
						state_q     <= S_SCAN;
					end else begin
						state_q <= S_NOWIN;
					end
				end
				S_SCAN: begin
					t_q <= t_q + 1'b1;
					if ((WIN_W'(t_q) + 1'b1) == we_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_q.window_index <= i_q[5:0];
						out_q.peak_sum     <= best_sum_q;
						out_q.peak_hits    <= best_hits_q;
						out_q.no_window    <= 1'b0;
						out_q.last         <= last_c;
						if (last_c) begin
							clr_q   <= '0;
							chan_q  <= '0;
							len_q   <= '0;
							state_q <= S_CLEAR;
						end else begin
							i_q     <= i_q + 1'b1;
							ws_q    <= we_q;
							state_q <= S_RCHECK;
						end
					end
				end
				S_NOWIN: begin
					if (out_free) begin
						out_q.window_index <= '0;
						out_q.peak_sum     <= '0;
						out_q.peak_hits    <= '0;
						out_q.no_window    <= 1'b1;
						out_q.last         <= 1'b1;
						clr_q              <= '0;
						chan_q             <= '0;
						len_q              <= '0;
						state_q            <= S_CLEAR;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("back state not one-hot");
	a_wr_after_dec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR |-> $past(state_q) == S_DEC)
		else $error("accumulator write without a read");
	a_scan_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> WIN_W'(t_q) < we_q)
		else $error("scan ran past window end");
	a_nowin_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.no_window |-> out_q.last)
		else $error("no-window result not marked last");
`endif

endmodule
